// File: design/nrth_pkg.sv
// Package for the nearest ray/triangle hit block.
// Holds payload structs, register indexes, widths and saturation helpers.
// No dependencies.
package nrth_pkg;

  localparam int CW   = 32;          // coordinate width, Q16.16
  localparam int FB   = 16;          // fraction bits
  localparam int MW   = 16;          // mesh id width
  localparam int DW   = 31;          // distance width
  localparam int IW   = DW - FB;     // integer bits of distance
  localparam int PW   = 2 * CW - FB; // shifted product width
  localparam int SW   = PW + 2;      // dot product sum width
  localparam int MAGW = SW - 1;      // magnitude of a positive dot sum
  localparam int AW   = 5;           // APB address width

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  localparam logic [DW-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic [MW-1:0]        mesh_id;
    logic                 last_triangle;
  } tri_t;

  typedef struct packed {
    logic                 hit_found;
    logic [DW-1:0]        hit_distance;
    logic signed [CW-1:0] hit_point_x;
    logic signed [CW-1:0] hit_point_y;
    logic signed [CW-1:0] hit_point_z;
    logic [MW-1:0]        hit_mesh;
  } hit_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } ray_t;

  // classified triangle handed from front to back
  typedef struct packed {
    logic            ok;
    logic [MAGW-1:0] a;
    logic [MAGW-1:0] nt;
    logic [MW-1:0]   mesh;
    logic            last;
  } cand_t;

  function automatic logic signed [CW-1:0] sat_d(input logic signed [CW:0] x);
    logic signed [CW-1:0] r;
    if (x[CW] != x[CW-1]) r = x[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    else r = x[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_p(input logic signed [PW:0] x);
    logic signed [CW-1:0] r;
    if ((&x[PW:CW-1]) || !(|x[PW:CW-1])) r = x[CW-1:0];
    else r = x[PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  // product shifted right by FB, floor
  function automatic logic signed [PW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p[2*CW-1:FB];
  endfunction

endpackage

// File: design/nearest_ray_triangle_hit.sv
// Top level of the nearest ray/triangle hit block.
// Depends on nrth_pkg, nrth_cfg, nrth_front, nrth_queue, nrth_back.
//
//   port group   dir  handshake              payload
//   apb          in   psel/penable/pready    paddr, pwdata, prdata
//   in           in   in_valid/in_ready      in_data (tri_t)
//   out          out  out_valid/out_ready    out_data (hit_t)
//
// Front takes a new triangle only once the last one is pushed to the queue.
// Back: a rejected triangle skips to the update, a saturated t skips the
// one-bit-a-cycle divider the rest run for t; a two-entry queue sits between.
// Reset is synchronous and clears control and the nearest-hit state; no sweep.
// A waiting beat stalls the back on the next last triangle, then the front.
module nearest_ray_triangle_hit import nrth_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_ready,
  input  tri_t          in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hit_t          out_data
);

  ray_t  ray;
  cand_t push_data, head;
  logic  push, pop, empty, full;

  nrth_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .ray
  );

  nrth_front u_front (
    .clk, .rst, .ray, .in_valid, .in_ready, .in_data,
    .q_full(full), .push, .push_data
  );

  nrth_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .empty, .full
  );

  nrth_back u_back (
    .clk, .rst, .ray, .head, .empty, .pop, .out_valid, .out_ready, .out_data
  );

endmodule

// File: design/nrth_cfg.sv
// APB register file holding the ray origin and direction.
// Depends on nrth_pkg.
module nrth_cfg import nrth_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ray_t          ray
);

  logic [2:0] idx;
  assign idx    = paddr[AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ORIGIN_X: ray.origin_x <= pwdata;
        REG_ORIGIN_Y: ray.origin_y <= pwdata;
        REG_ORIGIN_Z: ray.origin_z <= pwdata;
        REG_DIR_X:    ray.dir_x    <= pwdata;
        REG_DIR_Y:    ray.dir_y    <= pwdata;
        REG_DIR_Z:    ray.dir_z    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = ray.origin_x;
      REG_ORIGIN_Y: prdata = ray.origin_y;
      REG_ORIGIN_Z: prdata = ray.origin_z;
      REG_DIR_X:    prdata = ray.dir_x;
      REG_DIR_Y:    prdata = ray.dir_y;
      REG_DIR_Z:    prdata = ray.dir_z;
      default:      prdata = '0;
    endcase
  end

endmodule

// File: design/nrth_front.sv
// Front end: takes a triangle, runs the Moller-Trumbore dot products and tests,
// pushes a classified entry into the queue. Depends on nrth_pkg.
module nrth_front import nrth_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ray_t  ray,
  input  logic  in_valid,
  output logic  in_ready,
  input  tri_t  in_data,
  input  logic  q_full,
  output logic  push,
  output cand_t push_data
);

  logic [2:0] fstep;
  tri_t tri_q;

  logic signed [CW-1:0] o [3], d [3], v0 [3], v1 [3], v2 [3];
  logic signed [CW-1:0] e1 [3], e2 [3], s [3], h [3], q [3];
  logic signed [PW-1:0] ph_a [3], ph_b [3], pq_a [3], pq_b [3];
  logic signed [PW-1:0] pa [3], pu [3], pv [3], pt [3];

  assign o  = '{ray.origin_x, ray.origin_y, ray.origin_z};
  assign d  = '{ray.dir_x, ray.dir_y, ray.dir_z};
  assign v0 = '{tri_q.v0_x, tri_q.v0_y, tri_q.v0_z};
  assign v1 = '{tri_q.v1_x, tri_q.v1_y, tri_q.v1_z};
  assign v2 = '{tri_q.v2_x, tri_q.v2_y, tri_q.v2_z};

  assign in_ready = (fstep == 3'd0);

  // data stages run free; fstep says when the last one holds this triangle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1[i] <= sat_d($signed({v1[i][CW-1], v1[i]}) - $signed({v0[i][CW-1], v0[i]}));
      e2[i] <= sat_d($signed({v2[i][CW-1], v2[i]}) - $signed({v0[i][CW-1], v0[i]}));
      s[i]  <= sat_d($signed({o[i][CW-1], o[i]}) - $signed({v0[i][CW-1], v0[i]}));
    end
    ph_a[0] <= qmul(d[1], e2[2]);  ph_b[0] <= qmul(d[2], e2[1]);
    ph_a[1] <= qmul(d[2], e2[0]);  ph_b[1] <= qmul(d[0], e2[2]);
    ph_a[2] <= qmul(d[0], e2[1]);  ph_b[2] <= qmul(d[1], e2[0]);
    pq_a[0] <= qmul(s[1], e1[2]);  pq_b[0] <= qmul(s[2], e1[1]);
    pq_a[1] <= qmul(s[2], e1[0]);  pq_b[1] <= qmul(s[0], e1[2]);
    pq_a[2] <= qmul(s[0], e1[1]);  pq_b[2] <= qmul(s[1], e1[0]);
    for (int i = 0; i < 3; i++) begin
      h[i]  <= sat_p($signed({ph_a[i][PW-1], ph_a[i]}) - $signed({ph_b[i][PW-1], ph_b[i]}));
      q[i]  <= sat_p($signed({pq_a[i][PW-1], pq_a[i]}) - $signed({pq_b[i][PW-1], pq_b[i]}));
      pa[i] <= qmul(e1[i], h[i]);
      pu[i] <= qmul(s[i], h[i]);
      pv[i] <= qmul(d[i], q[i]);
      pt[i] <= qmul(e2[i], q[i]);
    end
  end

  function automatic logic signed [SW-1:0] sum3(input logic signed [PW-1:0] x0,
                                                input logic signed [PW-1:0] x1,
                                                input logic signed [PW-1:0] x2);
    return $signed({{2{x0[PW-1]}}, x0}) + $signed({{2{x1[PW-1]}}, x1})
         + $signed({{2{x2[PW-1]}}, x2});
  endfunction

  logic signed [SW-1:0] a_s, nu_s, nv_s, nt_s, a_p, nu_p, nv_p, nt_p;
  logic signed [SW:0]   uv;
  logic                 ok;

  always_comb begin
    a_s  = sum3(pa[0], pa[1], pa[2]);
    nu_s = sum3(pu[0], pu[1], pu[2]);
    nv_s = sum3(pv[0], pv[1], pv[2]);
    nt_s = sum3(pt[0], pt[1], pt[2]);
    if (a_s[SW-1]) begin
      a_p = -a_s;  nu_p = -nu_s;  nv_p = -nv_s;  nt_p = -nt_s;
    end else begin
      a_p = a_s;   nu_p = nu_s;   nv_p = nv_s;   nt_p = nt_s;
    end
    uv = $signed({nu_p[SW-1], nu_p}) + $signed({nv_p[SW-1], nv_p});
    ok = (a_p != '0) && !nu_p[SW-1] && (nu_p <= a_p) && !nv_p[SW-1]
      && (uv <= $signed({a_p[SW-1], a_p})) && !nt_p[SW-1] && (nt_p != '0);
  end

  assign push           = (fstep == 3'd5) && !q_full;
  assign push_data.ok   = ok;
  assign push_data.a    = a_p[MAGW-1:0];
  assign push_data.nt   = nt_p[MAGW-1:0];
  assign push_data.mesh = tri_q.mesh_id;
  assign push_data.last = tri_q.last_triangle;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) tri_q <= in_data;
    if (rst) begin
      fstep <= 3'd0;
    end else if (in_valid && in_ready) begin
      fstep <= 3'd1;
    end else if (fstep == 3'd5) begin
      if (!q_full) fstep <= 3'd0;
    end else if (fstep != 3'd0) begin
      fstep <= fstep + 3'd1;
    end
  end

endmodule

// File: design/nrth_queue.sv
// Two-entry queue of classified triangles between front and back.
// Depends on nrth_pkg.
module nrth_queue import nrth_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cand_t push_data,
  input  logic  pop,
  output cand_t head,
  output logic  empty,
  output logic  full
);

  cand_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/nrth_back.sv
// Back end: divides out t, forms the hit point, keeps the nearest hit and
// emits the result beat on the last triangle. Depends on nrth_pkg.
module nrth_back import nrth_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ray_t  ray,
  input  cand_t head,
  input  logic  empty,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output hit_t  out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL, ST_ADD, ST_UPD} state_t;

  state_t               state;
  logic [MAGW-1:0]      a_r, rem;
  logic [DW-1:0]        numsh, t_r;
  logic [4:0]           bitcnt;
  logic                 cand, last_r;
  logic [MW-1:0]        mesh_r;
  logic signed [PW-1:0] p [3];
  logic signed [CW-1:0] pt [3];

  logic                 have_hit;
  logic [DW-1:0]        best_dist;
  logic signed [CW-1:0] best_pt [3];
  logic [MW-1:0]        best_mesh;

  logic signed [CW-1:0] o [3], d [3];
  assign o = '{ray.origin_x, ray.origin_y, ray.origin_z};
  assign d = '{ray.dir_x, ray.dir_y, ray.dir_z};

  logic          ovf, upd, emit_ok, emit;
  logic [MAGW:0] rem2;

  assign pop     = (state == ST_IDLE) && !empty;
  assign ovf     = {{IW{1'b0}}, head.nt} >= {head.a, {IW{1'b0}}};
  assign rem2    = {rem, numsh[DW-1]};
  assign upd     = cand && (!have_hit || t_r < best_dist);
  assign emit_ok = !out_valid || out_ready;
  assign emit    = (state == ST_UPD) && last_r && emit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      have_hit  <= 1'b0;
      best_dist <= '0;
      best_pt   <= '{default: '0};
      best_mesh <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            a_r    <= head.a;
            mesh_r <= head.mesh;
            last_r <= head.last;
            rem    <= {{IW{1'b0}}, head.nt[MAGW-1:IW]};
            numsh  <= {head.nt[IW-1:0], {FB{1'b0}}};
            bitcnt <= '0;
            if (!head.ok) begin
              cand  <= 1'b0;
              state <= ST_UPD;
            end else if (ovf) begin
              t_r   <= DIST_MAX;
              state <= ST_MUL;
            end else begin
              t_r   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a beat
          if (rem2 >= {1'b0, a_r}) begin
            rem <= MAGW'(rem2 - {1'b0, a_r});
            t_r <= {t_r[DW-2:0], 1'b1};
          end else begin
            rem <= rem2[MAGW-1:0];
            t_r <= {t_r[DW-2:0], 1'b0};
          end
          numsh  <= {numsh[DW-2:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'(DW - 1)) state <= ST_MUL;
        end
        ST_MUL: begin
          for (int i = 0; i < 3; i++) p[i] <= qmul(d[i], $signed({1'b0, t_r}));
          cand  <= (t_r != '0);
          state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 3; i++)
            pt[i] <= sat_p($signed({{(PW+1-CW){o[i][CW-1]}}, o[i]})
                         + $signed({p[i][PW-1], p[i]}));
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (!last_r) begin
            if (upd) begin
              have_hit  <= 1'b1;
              best_dist <= t_r;
              best_pt   <= pt;
              best_mesh <= mesh_r;
            end
            state <= ST_IDLE;
          end else if (emit_ok) begin
            out_data.hit_found <= have_hit || upd;
            if (upd) begin
              out_data.hit_distance <= t_r;
              out_data.hit_point_x  <= pt[0];
              out_data.hit_point_y  <= pt[1];
              out_data.hit_point_z  <= pt[2];
              out_data.hit_mesh     <= mesh_r;
            end else begin
              out_data.hit_distance <= best_dist;
              out_data.hit_point_x  <= best_pt[0];
              out_data.hit_point_y  <= best_pt[1];
              out_data.hit_point_z  <= best_pt[2];
              out_data.hit_mesh     <= best_mesh;
            end
            have_hit  <= 1'b0;
            best_dist <= '0;
            best_pt   <= '{default: '0};
            best_mesh <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < a_r))
    else $error("divider remainder not below divisor");

  a_hit_has_distance: assert property (@(posedge clk) disable iff (rst)
    have_hit |-> (best_dist != '0))
    else $error("kept hit with zero distance");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && last_r && emit_ok) |=> (out_valid && !have_hit))
    else $error("result beat not issued or state not cleared");

endmodule

// File: bench/nearest_ray_triangle_hit_tb.sv
// Testbench for nearest_ray_triangle_hit: triangle streams against several rays,
// checked beat by beat against a fixed-point Moller-Trumbore predictor.
// Depends on nrth_pkg and the block's RTL.
`timescale 1ns / 100ps

module nearest_ray_triangle_hit_tb;
  import nrth_pkg::*;

  class hit_scoreboard;
    longint ray_reg[6];
    bit     have_hit;
    longint best_dist, best_x, best_y, best_z;
    logic [MW-1:0] best_mesh;
    hit_t   expected_hits[$];
    int     errors;
    int     hits_seen, misses_seen, tris_seen;

    function void set_reg(int idx, logic [31:0] val);
      ray_reg[idx] = longint'($signed(val));
    endfunction

    function longint clamp(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Q16.16 product, floor
    function longint qm(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    function void note_triangle(tri_t tr);
      longint o[3], d[3], v0[3], v1[3], v2[3], e1[3], e2[3], s[3], h[3], q[3];
      longint a, nu, nv, nt, tint, rem, t;
      hit_t r;
      tris_seen++;
      for (int i = 0; i < 3; i++) begin
        o[i] = ray_reg[i];
        d[i] = ray_reg[3+i];
      end
      v0 = '{tr.v0_x, tr.v0_y, tr.v0_z};
      v1 = '{tr.v1_x, tr.v1_y, tr.v1_z};
      v2 = '{tr.v2_x, tr.v2_y, tr.v2_z};
      for (int i = 0; i < 3; i++) begin
        e1[i] = clamp(v1[i] - v0[i]);
        e2[i] = clamp(v2[i] - v0[i]);
        s[i]  = clamp(o[i] - v0[i]);
      end
      h[0] = clamp(qm(d[1], e2[2]) - qm(d[2], e2[1]));
      h[1] = clamp(qm(d[2], e2[0]) - qm(d[0], e2[2]));
      h[2] = clamp(qm(d[0], e2[1]) - qm(d[1], e2[0]));
      q[0] = clamp(qm(s[1], e1[2]) - qm(s[2], e1[1]));
      q[1] = clamp(qm(s[2], e1[0]) - qm(s[0], e1[2]));
      q[2] = clamp(qm(s[0], e1[1]) - qm(s[1], e1[0]));
      a  = qm(e1[0], h[0]) + qm(e1[1], h[1]) + qm(e1[2], h[2]);
      nu = qm(s[0], h[0]) + qm(s[1], h[1]) + qm(s[2], h[2]);
      nv = qm(d[0], q[0]) + qm(d[1], q[1]) + qm(d[2], q[2]);
      nt = qm(e2[0], q[0]) + qm(e2[1], q[1]) + qm(e2[2], q[2]);
      if (a < 0) begin
        a = -a; nu = -nu; nv = -nv; nt = -nt;
      end
      if (a != 0 && nu >= 0 && nu <= a && nv >= 0 && nu + nv <= a && nt > 0) begin
        tint = nt / a;
        rem  = nt % a;
        if (tint >= (64'sd1 <<< IW)) t = 64'sd2147483647;
        else begin
          t = tint;
          // restoring division for the fraction bits
          for (int i = 0; i < FB; i++) begin
            rem = rem <<< 1;
            t = t <<< 1;
            if (rem >= a) begin
              rem -= a;
              t |= 1;
            end
          end
        end
        // ties keep the earlier triangle
        if (t > 0 && (!have_hit || t < best_dist)) begin
          have_hit  = 1;
          best_dist = t;
          best_x    = clamp(o[0] + qm(d[0], t));
          best_y    = clamp(o[1] + qm(d[1], t));
          best_z    = clamp(o[2] + qm(d[2], t));
          best_mesh = tr.mesh_id;
        end
      end
      if (tr.last_triangle) begin
        r.hit_found    = have_hit;
        r.hit_distance = best_dist[DW-1:0];
        r.hit_point_x  = best_x[CW-1:0];
        r.hit_point_y  = best_y[CW-1:0];
        r.hit_point_z  = best_z[CW-1:0];
        r.hit_mesh     = best_mesh;
        expected_hits.insert(expected_hits.size(), r);
        have_hit = 0;
        best_dist = 0; best_x = 0; best_y = 0; best_z = 0;
        best_mesh = '0;
      end
    endfunction

    task check_hit(hit_t got);
      hit_t want;
      if (expected_hits.size() == 0) begin
        report("unexpected beat", longint'(got.hit_distance), 0);
        return;
      end
      want = expected_hits.pop_front();
      if (want.hit_found) hits_seen++;
      else misses_seen++;
      if (got.hit_found !== want.hit_found)
        report("hit_found", got.hit_found, want.hit_found);
      if (got.hit_distance !== want.hit_distance)
        report("hit_distance", got.hit_distance, want.hit_distance);
      if (got.hit_point_x !== want.hit_point_x)
        report("hit_point_x", got.hit_point_x, want.hit_point_x);
      if (got.hit_point_y !== want.hit_point_y)
        report("hit_point_y", got.hit_point_y, want.hit_point_y);
      if (got.hit_point_z !== want.hit_point_z)
        report("hit_point_z", got.hit_point_z, want.hit_point_z);
      if (got.hit_mesh !== want.hit_mesh)
        report("hit_mesh", got.hit_mesh, want.hit_mesh);
    endtask
  endclass

  logic          clk = 0;
  logic          rst = 1;
  logic          psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid = 0;
  logic          in_ready;
  tri_t          in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  hit_t          out_data;

  hit_scoreboard sb = new();
  ray_t  cur_ray;
  bit    hold_req = 0;
  int    burst_left = 0;
  int    query_left = 0;
  int    phase_count = 0;

  always #5 clk = ~clk;

  nearest_ray_triangle_hit DUT (.*);

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_triangle(in_data);
    if (!rst && out_valid && out_ready) sb.check_hit(out_data);
  end

  // receiver: rotates between always ready, random and mostly stalled,
  // with an occasional long hold-off on request
  initial begin
    int mode;
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 2);
        repeat (64) begin
          @(posedge clk);
          case (mode)
            0: out_ready <= 1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("nearest_ray_triangle_hit regression: fail");
    $finish;
  end

  task reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task wait_drained;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    // triangles that end no query may still be in flight
    repeat (200) @(posedge clk);
  endtask

  task load_ray(ray_t r);
    wait_drained();
    reg_write(REG_ORIGIN_X, r.origin_x);
    reg_write(REG_ORIGIN_Y, r.origin_y);
    reg_write(REG_ORIGIN_Z, r.origin_z);
    reg_write(REG_DIR_X, r.dir_x);
    reg_write(REG_DIR_Y, r.dir_y);
    reg_write(REG_DIR_Z, r.dir_z);
    cur_ray = r;
    phase_count++;
  endtask

  // one beat; valid stays high into the next beat unless a gap follows
  task send_tri(tri_t tr);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1;
    in_data <= tr;
    do @(posedge clk); while (!in_ready);
  endtask

  task idle_input;
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic longint q16(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic logic [31:0] srnd(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // triangle whose centroid lies on the ray at parameter k
  function automatic tri_t aimed_tri(longint k);
    tri_t tr;
    longint p[3], aa[3], bb[3];
    p[0] = longint'(cur_ray.origin_x) + q16(cur_ray.dir_x, k);
    p[1] = longint'(cur_ray.origin_y) + q16(cur_ray.dir_y, k);
    p[2] = longint'(cur_ray.origin_z) + q16(cur_ray.dir_z, k);
    for (int i = 0; i < 3; i++) begin
      aa[i] = $signed(srnd(1 << 18));
      bb[i] = $signed(srnd(1 << 18));
    end
    tr.v0_x = CW'(p[0] - aa[0] - bb[0]);
    tr.v0_y = CW'(p[1] - aa[1] - bb[1]);
    tr.v0_z = CW'(p[2] - aa[2] - bb[2]);
    tr.v1_x = CW'(p[0] + 2 * aa[0] - bb[0]);
    tr.v1_y = CW'(p[1] + 2 * aa[1] - bb[1]);
    tr.v1_z = CW'(p[2] + 2 * aa[2] - bb[2]);
    tr.v2_x = CW'(p[0] - aa[0] + 2 * bb[0]);
    tr.v2_y = CW'(p[1] - aa[1] + 2 * bb[1]);
    tr.v2_z = CW'(p[2] - aa[2] + 2 * bb[2]);
    tr.mesh_id = MW'($urandom);
    tr.last_triangle = 0;
    return tr;
  endfunction

  function automatic tri_t noise_tri();
    tri_t tr;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    tr = raw[$bits(tri_t)-1:0];
    return tr;
  endfunction

  function automatic ray_t small_ray();
    ray_t r;
    r.origin_x = srnd(1 << 20);
    r.origin_y = srnd(1 << 20);
    r.origin_z = srnd(1 << 20);
    r.dir_x = srnd(1 << 16);
    r.dir_y = srnd(1 << 16);
    r.dir_z = srnd(1 << 16);
    return r;
  endfunction

  task random_stream(int count, bit squeeze);
    tri_t tr;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 3) hold_req = 1;
      if (squeeze && n == 2 * count / 3) begin
        idle_input();
        while (sb.expected_hits.size() != 0) @(posedge clk);
      end
      if (query_left == 0) query_left = $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1: tr = noise_tri();
        2:    tr = aimed_tri($urandom_range(0, 1) ? 64'sd32767 << 16 : -longint'($urandom_range(1, 1 << 20)));
        default: tr = aimed_tri($urandom_range(1, 1 << 20));
      endcase
      query_left--;
      tr.last_triangle = (query_left == 0);
      send_tri(tr);
    end
  endtask

  initial begin
    tri_t tr;
    ray_t r;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset ray: zero direction, nothing can hit
    cur_ray = '0;
    tr = '1;
    send_tri(tr);
    tr = '0; tr.last_triangle = 1;
    send_tri(tr);
    random_stream(40, 0);
    idle_input();

    // straight down +z, directed cases
    r = '0; r.dir_z = 32'sh0001_0000;
    load_ray(r);
    tr = aimed_tri(64'sd3 << 16); tr.mesh_id = 16'h0000;
    send_tri(tr);
    tr.mesh_id = 16'hffff;                          // tie: earlier kept
    send_tri(tr);
    tr = aimed_tri(64'sd1 << 16); tr.mesh_id = 16'h1234; tr.last_triangle = 1;
    send_tri(tr);
    tr = aimed_tri(-(64'sd2 << 16)); tr.last_triangle = 1;  // behind origin
    send_tri(tr);
    tr = aimed_tri(64'sd2 << 16);
    tr.v1_x = tr.v0_x; tr.v1_y = tr.v0_y; tr.v1_z = tr.v0_z;  // degenerate
    tr.last_triangle = 1;
    send_tri(tr);
    tr = aimed_tri(64'sd40000 << 16); tr.last_triangle = 1;  // far: vertex z wraps, lands behind origin
    send_tri(tr);
    tr = '0;
    tr.v0_x = 32'sh8000_0000; tr.v1_y = 32'sh7fff_ffff; tr.v2_z = 32'sh7fff_ffff;
    tr.v0_z = 32'sh8000_0000; tr.last_triangle = 1;
    send_tri(tr);
    tr = noise_tri(); tr.last_triangle = 0;
    send_tri(tr);
    tr = noise_tri(); tr.last_triangle = 1;
    send_tri(tr);
    idle_input();

    for (int p = 0; p < 4; p++) begin
      load_ray(small_ray());
      random_stream(110, p == 1);
      idle_input();
    end

    r = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    load_ray(r);
    random_stream(30, 0);
    idle_input();
    r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    load_ray(r);
    random_stream(30, 0);
    idle_input();

    for (int w = 0; w < 200000 && sb.expected_hits.size() != 0; w++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.expected_hits.size() != 0) sb.report("beats never seen", sb.expected_hits.size(), 0);

    $display("covered %0d triangles over %0d ray settings", sb.tris_seen, phase_count + 1);
    $display("queries checked: %0d with a hit, %0d without", sb.hits_seen, sb.misses_seen);
    if (sb.errors == 0) $display("nearest_ray_triangle_hit regression: pass");
    else $display("nearest_ray_triangle_hit regression: fail");
    $finish;
  end

endmodule
